// ----- hw/rtl/peq_pkg.sv -----
// Shared types and codes for the priority event queue.
`timescale 1ns / 1ps

package peq_pkg;

    localparam logic [2:0] FUNC_REGISTER  = 3'd0;
    localparam logic [2:0] FUNC_SEND_CHK  = 3'd1;
    localparam logic [2:0] FUNC_SEND_RAW  = 3'd2;
    localparam logic [2:0] FUNC_CANCEL    = 3'd3;
    localparam logic [2:0] FUNC_FIND      = 3'd4;
    localparam logic [2:0] FUNC_DISPATCH  = 3'd5;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_UNKNOWN_RCV = 3'd1;
    localparam logic [2:0] ST_FULL        = 3'd2;
    localparam logic [2:0] ST_EMPTY       = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND   = 3'd4;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd5;

    localparam int HANDLE_W = 4;
    localparam int MAX_SLOTS = 16;

    // One queued event
    typedef struct packed {
        logic [1:0]          priority_v;
        logic [7:0]          receiver;
        logic [7:0]          sender;
        logic [7:0]          ev_kind;
        logic [7:0]          event_ident;
        logic [31:0]         event_word;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // Broadcast command from the controller to every cell
    typedef struct packed {
        logic   insert;
        logic   remove;
        entry_t ins_entry;
        logic [HANDLE_W-1:0] rm_handle;
    } cell_cmd_t;

    // Per-cell status toward the controller
    typedef struct packed {
        logic valid;
        logic stays;
        logic hit_handle;
        logic hit_find;
    } cell_stat_t;

endpackage

// ----- hw/rtl/peq_cell.sv -----
// One slot of the ordered event chain.
`timescale 1ns / 1ps

module peq_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  peq_pkg::cell_cmd_t    cmd,
    input  logic [7:0]            find_receiver,
    input  logic [7:0]            find_ident,
    input  logic [peq_pkg::HANDLE_W-1:0] find_handle,
    input  logic                  left_valid,
    input  logic                  left_stays,
    input  peq_pkg::entry_t       left_entry,
    input  logic                  left_removed,
    input  logic                  right_valid,
    input  peq_pkg::entry_t       right_entry,
    output logic                  valid,
    output logic                  stays,
    output logic                  removed,
    output peq_pkg::entry_t       entry,
    output peq_pkg::cell_stat_t   stat
);

    logic            valid_reg;
    logic            valid_next;
    peq_pkg::entry_t entry_reg;
    peq_pkg::entry_t entry_next;
    logic            hit_h;

    // Entry stays ahead of a new event when its priority is not larger
    assign stays = valid_reg && (entry_reg.priority_v <= cmd.ins_entry.priority_v);
    assign hit_h = valid_reg && (entry_reg.handle == cmd.rm_handle);
    // Removal point at or ahead of this cell
    assign removed = left_removed || hit_h;

    assign valid = valid_reg;
    assign entry = entry_reg;
    assign stat.valid      = valid_reg;
    assign stat.stays      = stays;
    assign stat.hit_handle = valid_reg && (entry_reg.handle == find_handle);
    assign stat.hit_find   = valid_reg && entry_reg.receiver == find_receiver
                             && entry_reg.event_ident == find_ident;

    // Shift right on insert, shift left on remove
    always_comb
    begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (cmd.insert)
        begin
            if (!stays)
            begin
                if (left_stays)
                begin
                    valid_next = 1'b1;
                    entry_next = cmd.ins_entry;
                end
                else
                begin
                    valid_next = left_valid;
                    entry_next = left_entry;
                end
            end
        end
        else if (cmd.remove)
        begin
            if (removed)
            begin
                valid_next = right_valid;
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- hw/rtl/priority_event_queue.sv -----
// Top level: stable priority event queue built as a chain of slot cells.
//
//  channel | tvalid/tready     | tdata / tuser
//  s_axis  | s_tvalid/s_tready | tdata: op fields, tuser: func
//  m_axis  | m_tvalid/m_tready | tdata: result fields, tuser: status
//
// Each word is evaluated against the cell chain and its result is
// registered; the cells then shift if it inserts or removes. A new
// word is taken only when no shift is pending and the result register
// is empty, so a result waiting for m_tready stalls the input.
// Reset clears valid bits, handle map and handler count.
`timescale 1ns / 1ps

module priority_event_queue #(
    parameter int QUEUE_DEPTH  = 16,
    parameter int MAX_HANDLERS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: priority_req[1:0], receiver[9:2], sender[17:10], ev_kind[25:18],
    //        event_ident[33:26], event_word[65:34], handle[69:66], zero fill
    input  logic [71:0] s_tdata,
    // tuser: func[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: handle_out[3:0], new_handler_id[7:4], priority_out[9:8],
    //        receiver_out[17:10], sender_out[25:18], type_out[33:26],
    //        ident_out[41:34], word_out[73:42], zero fill
    output logic [79:0] m_tdata,
    // tuser: status[2:0]
    output logic [2:0]  m_tuser
);

    localparam int CAP = (QUEUE_DEPTH < peq_pkg::MAX_SLOTS) ? QUEUE_DEPTH
                                                           : peq_pkg::MAX_SLOTS;
    localparam int HC_W = $clog2(MAX_HANDLERS + 1);
    localparam int HW = peq_pkg::HANDLE_W;

    // Input fields
    logic [2:0]  func;
    logic [1:0]  priority_req;
    logic [7:0]  receiver;
    logic [7:0]  sender;
    logic [7:0]  ev_kind;
    logic [7:0]  event_ident;
    logic [31:0] event_word;
    logic [HW-1:0] handle;

    assign func         = s_tuser;
    assign priority_req = s_tdata[1:0];
    assign receiver     = s_tdata[9:2];
    assign sender       = s_tdata[17:10];
    assign ev_kind      = s_tdata[25:18];
    assign event_ident  = s_tdata[33:26];
    assign event_word   = s_tdata[65:34];
    assign handle       = s_tdata[69:66];

    // Control state
    logic                  shift_pend_reg;
    logic                  shift_pend_next;
    peq_pkg::cell_cmd_t    cmd_reg;
    peq_pkg::cell_cmd_t    cmd_next;
    logic [15:0]           handles_reg;
    logic [15:0]           handles_next;
    logic [HC_W-1:0]       hcount_reg;
    logic [HC_W-1:0]       hcount_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [2:0]            status_reg;
    logic [2:0]            status_next;
    logic [79:0]           odata_reg;
    logic [79:0]           odata_next;

    // Chain wiring
    logic                  c_valid   [CAP];
    logic                  c_stays   [CAP];
    logic                  c_removed [CAP];
    peq_pkg::entry_t       c_entry   [CAP];
    peq_pkg::cell_stat_t   c_stat    [CAP];

    genvar g;
    generate
        for (g = 0; g < CAP; g++)
        begin : g_cell
            logic            lv, ls, lr, rv;
            peq_pkg::entry_t le, re;
            if (g == 0)
            begin : g_head
                assign lv = 1'b0;
                assign ls = 1'b1;
                assign lr = 1'b0;
                assign le = '0;
            end
            else
            begin : g_mid
                assign lv = c_valid[g-1];
                assign ls = c_stays[g-1];
                assign lr = c_removed[g-1];
                assign le = c_entry[g-1];
            end
            if (g == CAP - 1)
            begin : g_tail
                assign rv = 1'b0;
                assign re = '0;
            end
            else
            begin : g_body
                assign rv = c_valid[g+1];
                assign re = c_entry[g+1];
            end
            peq_cell u_cell
            (
                .clk           (clk),
                .rst_n         (rst_n),
                .cmd           (cmd_reg),
                .find_receiver (receiver),
                .find_ident    (event_ident),
                .find_handle   (handle),
                .left_valid    (lv),
                .left_stays    (ls),
                .left_entry    (le),
                .left_removed  (lr),
                .right_valid   (rv),
                .right_entry   (re),
                .valid         (c_valid[g]),
                .stays         (c_stays[g]),
                .removed       (c_removed[g]),
                .entry         (c_entry[g]),
                .stat          (c_stat[g])
            );
        end
    endgenerate

    // Scan chain status: full, empty, handle hit, first find hit, lowest free handle
    logic            q_full;
    logic            q_empty;
    logic            h_hit;
    logic            f_hit;
    peq_pkg::entry_t f_entry;
    logic            free_ok;
    logic [HW-1:0]   free_h;

    always_comb
    begin
        q_full  = c_stat[CAP-1].valid;
        q_empty = !c_stat[0].valid;
        h_hit   = 1'b0;
        f_hit   = 1'b0;
        f_entry = '0;
        for (int i = 0; i < CAP; i++)
        begin
            if (c_stat[i].hit_handle)
                h_hit = 1'b1;
            if (c_stat[i].hit_find && !f_hit)
            begin
                f_hit   = 1'b1;
                f_entry = c_entry[i];
            end
        end
        free_ok = 1'b0;
        free_h  = '0;
        for (int i = CAP - 1; i >= 0; i--)
        begin
            if (!handles_reg[i])
            begin
                free_ok = 1'b1;
                free_h  = HW'(i);
            end
        end
    end

    assign s_tready = !shift_pend_reg && !out_valid_reg;

    // Evaluate an accepted word, register the result and the cell command
    always_comb
    begin
        logic            do_ins;
        peq_pkg::entry_t ne;
        do_ins          = 1'b0;
        ne              = '0;
        shift_pend_next = 1'b0;
        cmd_next        = '0;
        handles_next    = handles_reg;
        hcount_next     = hcount_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        status_next     = status_reg;
        odata_next      = odata_reg;
        if (s_tvalid && s_tready)
        begin
            out_valid_next = 1'b1;
            status_next    = peq_pkg::ST_OK;
            odata_next     = '0;
            unique case (func)
                peq_pkg::FUNC_REGISTER:
                begin
                    if (32'(hcount_reg) >= 32'(MAX_HANDLERS))
                        status_next = peq_pkg::ST_TABLE_FULL;
                    else if (q_full || !free_ok)
                        status_next = peq_pkg::ST_FULL;
                    else
                    begin
                        do_ins = 1'b1;
                        ne.priority_v = 2'd3;
                        ne.receiver   = 8'(hcount_reg);
                        ne.ev_kind    = ev_kind;
                        odata_next[7:4] = 4'(hcount_reg);
                        hcount_next   = hcount_reg + 1'b1;
                    end
                end
                peq_pkg::FUNC_SEND_CHK,
                peq_pkg::FUNC_SEND_RAW:
                begin
                    if (func == peq_pkg::FUNC_SEND_CHK
                        && 32'(receiver) >= 32'(hcount_reg))
                        status_next = peq_pkg::ST_UNKNOWN_RCV;
                    else if (q_full || !free_ok)
                        status_next = peq_pkg::ST_FULL;
                    else
                    begin
                        do_ins = 1'b1;
                        ne.priority_v  = priority_req;
                        ne.receiver    = receiver;
                        ne.sender      = sender;
                        ne.ev_kind     = ev_kind;
                        ne.event_ident = event_ident;
                        ne.event_word  = event_word;
                    end
                end
                peq_pkg::FUNC_CANCEL:
                begin
                    if (!h_hit)
                        status_next = peq_pkg::ST_NOT_FOUND;
                    else
                    begin
                        shift_pend_next    = 1'b1;
                        cmd_next.remove    = 1'b1;
                        cmd_next.rm_handle = handle;
                        handles_next[handle] = 1'b0;
                    end
                end
                peq_pkg::FUNC_FIND:
                begin
                    if (!f_hit)
                        status_next = peq_pkg::ST_NOT_FOUND;
                    else
                    begin
                        odata_next[3:0]   = f_entry.handle;
                        odata_next[9:8]   = f_entry.priority_v;
                        odata_next[17:10] = f_entry.receiver;
                        odata_next[25:18] = f_entry.sender;
                        odata_next[33:26] = f_entry.ev_kind;
                        odata_next[41:34] = f_entry.event_ident;
                        odata_next[73:42] = f_entry.event_word;
                    end
                end
                peq_pkg::FUNC_DISPATCH:
                begin
                    if (q_empty)
                        status_next = peq_pkg::ST_EMPTY;
                    else
                    begin
                        odata_next[3:0]   = c_entry[0].handle;
                        odata_next[9:8]   = c_entry[0].priority_v;
                        odata_next[17:10] = c_entry[0].receiver;
                        odata_next[25:18] = c_entry[0].sender;
                        odata_next[33:26] = c_entry[0].ev_kind;
                        odata_next[41:34] = c_entry[0].event_ident;
                        odata_next[73:42] = c_entry[0].event_word;
                        shift_pend_next    = 1'b1;
                        cmd_next.remove    = 1'b1;
                        cmd_next.rm_handle = c_entry[0].handle;
                        handles_next[c_entry[0].handle] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            if (do_ins)
            begin
                ne.handle          = free_h;
                odata_next[3:0]    = free_h;
                shift_pend_next    = 1'b1;
                cmd_next.insert    = 1'b1;
                cmd_next.ins_entry = ne;
                handles_next[free_h] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_pend_reg <= 1'b0;
            cmd_reg        <= '0;
            handles_reg    <= '0;
            hcount_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            shift_pend_reg <= shift_pend_next;
            cmd_reg        <= cmd_next;
            handles_reg    <= handles_next;
            hcount_reg     <= hcount_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        odata_reg  <= odata_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = odata_reg;
    assign m_tuser  = status_reg;

`ifndef ASSERT_OFF
    // A cell command lasts exactly one cycle
    a_cmd_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        shift_pend_reg |=> !shift_pend_reg)
        else $error("shift command held");

    // Insert and remove never issue together
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_reg.insert && cmd_reg.remove))
        else $error("insert and remove together");

    // Handler count never passes the table size
    a_hcount: assert property (@(posedge clk) disable iff (!rst_n)
        32'(hcount_reg) <= 32'(MAX_HANDLERS))
        else $error("handler count overflow");

    // Valid bits stay compact from the head
    a_compact: assert property (@(posedge clk) disable iff (!rst_n)
        !c_valid[0] |-> !c_valid[CAP-1])
        else $error("chain not compact");
`endif

endmodule
